>>> sv/rlk_pkg.sv
// ----------------------------------------------------------------------------
// rlk_pkg
// shared types and codes for the ipv4 route lookup core
// ----------------------------------------------------------------------------
package rlk_pkg;

    localparam int ROUTES_DEF = 16;
    localparam int IFACES_DEF = 16;

    // result status codes
    localparam logic [1:0] ST_ROUTED  = 2'd0;
    localparam logic [1:0] ST_NOROUTE = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;

    // request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_ROUTE_COUNT = 2'd0;
    localparam logic [1:0] CFG_GW_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_GW_IFACE    = 2'd2;

    // lookup token passed from cell to cell
    typedef struct packed {
        logic [31:0] dest;
        logic        hit;
        logic        found;
        logic [3:0]  iface;
        logic        ext;
    } tok_t;

    // configuration seen by every cell
    typedef struct packed {
        logic [4:0] route_count;
        logic       gw_present;
        logic [3:0] gw_iface;
    } cfg_t;

    // entry write broadcast to the cells
    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [31:0] mask;
        logic [31:0] value;
        logic [5:0]  prefix;
        logic [3:0]  iface;
    } wr_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] iface;
        logic       ext;
    } res_t;

endpackage

>>> sv/rlk_cell.sv
// ----------------------------------------------------------------------------
// rlk_cell
// one route table entry plus its compare stage in the lookup chain
// ----------------------------------------------------------------------------
module rlk_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  rlk_pkg::tok_t in_tok,
    input  rlk_pkg::cfg_t cfg,
    input  rlk_pkg::wr_t  wr,
    output logic          out_valid,
    output rlk_pkg::tok_t out_tok
);

    logic [31:0]   mask_reg;
    logic [31:0]   value_reg;
    logic [5:0]    prefix_reg;
    logic [3:0]    iface_reg;
    logic          valid_reg;
    rlk_pkg::tok_t tok_reg;
    rlk_pkg::tok_t tok_next;
    logic          active;
    logic          match;

    // entry storage, loaded by a write item addressed to this slot
    always_ff @(posedge clk)
    begin
        if (wr.en && (9'(wr.index) == 9'(IDX)))
        begin
            mask_reg   <= wr.mask;
            value_reg  <= wr.value;
            prefix_reg <= wr.prefix;
            iface_reg  <= wr.iface;
        end
    end

    assign active = 9'(cfg.route_count) > 9'(IDX);
    assign match  = active && !in_tok.hit && ((in_tok.dest & mask_reg) == value_reg);

    always_comb
    begin
        tok_next = in_tok;
        if (match)
        begin
            tok_next.hit = 1'b1;
            if (prefix_reg != 6'd0)
            begin
                tok_next.found = 1'b1;
                tok_next.iface = iface_reg;
                tok_next.ext   = 1'b0;
            end
            else if (cfg.gw_present)
            begin
                tok_next.found = 1'b1;
                tok_next.iface = cfg.gw_iface;
                tok_next.ext   = 1'b1;
            end
            else
            begin
                // default route without gateway ends the scan unrouted
                tok_next.found = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

>>> sv/ipv4_route_lookup_core.sv
// ----------------------------------------------------------------------------
// ipv4_route_lookup_core
// route table lookup built as a chain of entry cells
// ----------------------------------------------------------------------------
// A lookup item walks down a row of ROUTES cells, one cell per cycle. Its
// result is pushed toward the output as the token leaves the last cell, and
// the next item can be taken once busy clears after that push. A lookup thus
// holds the input while its token walks the whole cell chain. A write item
// loads its table slot at acceptance, answers from a registered pending flag
// and holds the input until that answer is pushed. One item is in flight at
// a time. A finished result waits in the output register while the next item
// is taken, and a second waiting result stalls the input until the first one
// is taken. Table entries hold no reset value and must be written before a
// lookup scans them.
module ipv4_route_lookup_core #(
    parameter int ROUTES = rlk_pkg::ROUTES_DEF,
    parameter int IFACES = rlk_pkg::IFACES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dest_addr, entry_index, entry_mask, entry_value, entry_prefix,
    // entry_iface, zero pad
    input  logic [111:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_iface, via_gw, zero pad
    output logic [7:0]   m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    rlk_pkg::cfg_t cfg_reg;
    rlk_pkg::wr_t  wr;
    rlk_pkg::res_t res;
    rlk_pkg::res_t out_reg;
    rlk_pkg::res_t skid_reg;
    rlk_pkg::tok_t chain_tok [ROUTES+1];
    logic [ROUTES:0] chain_valid;

    logic s_fire;
    logic out_pop;
    logic res_push;
    logic busy_reg, busy_next;
    logic wr_pend_reg;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic iface_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                rlk_pkg::CFG_ROUTE_COUNT: cfg_reg.route_count <= cfg_data;
                rlk_pkg::CFG_GW_PRESENT:  cfg_reg.gw_present  <= cfg_data[0];
                rlk_pkg::CFG_GW_IFACE:    cfg_reg.gw_iface    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !busy_reg && !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_pop  = out_valid_reg && m_tready;

    assign wr.en     = s_fire && (s_tuser == rlk_pkg::REQ_WRITE);
    assign wr.index  = s_tdata[35:32];
    assign wr.mask   = s_tdata[67:36];
    assign wr.value  = s_tdata[99:68];
    assign wr.prefix = s_tdata[105:100];
    assign wr.iface  = s_tdata[109:106];

    // token enters the first cell with nothing matched yet
    assign chain_valid[0]     = s_fire && (s_tuser == rlk_pkg::REQ_LOOKUP);
    assign chain_tok[0].dest  = s_tdata[31:0];
    assign chain_tok[0].hit   = 1'b0;
    assign chain_tok[0].found = 1'b0;
    assign chain_tok[0].iface = 4'd0;
    assign chain_tok[0].ext   = 1'b0;

    for (genvar g = 0; g < ROUTES; g++)
    begin : g_cell
        rlk_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_tok    (chain_tok[g]),
            .cfg       (cfg_reg),
            .wr        (wr),
            .out_valid (chain_valid[g+1]),
            .out_tok   (chain_tok[g+1])
        );
    end

    assign iface_ok = 9'(chain_tok[ROUTES].iface) < 9'(IFACES);
    assign res_push = chain_valid[ROUTES] || wr_pend_reg;

    always_comb
    begin
        if (wr_pend_reg)
        begin
            res.status = rlk_pkg::ST_WRITTEN;
            res.iface  = 4'd0;
            res.ext    = 1'b0;
        end
        else if (chain_tok[ROUTES].found && iface_ok)
        begin
            res.status = rlk_pkg::ST_ROUTED;
            res.iface  = chain_tok[ROUTES].iface;
            res.ext    = chain_tok[ROUTES].ext;
        end
        else
        begin
            res.status = rlk_pkg::ST_NOROUTE;
            res.iface  = 4'd0;
            res.ext    = 1'b0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (s_fire)
            busy_next = 1'b1;
        else if (res_push)
            busy_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = res_push;
            end
            else
                out_valid_next = res_push;
        end
        else if (res_push)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            wr_pend_reg    <= wr.en;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (res_push)
                    skid_reg <= res;
            end
            else if (res_push)
                out_reg <= res;
        end
        else if (res_push)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'd0, out_reg.ext, out_reg.iface};

    // skid stage only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    // a result appears only for an item in flight
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> busy_reg)
        else $error("result produced with no item in flight");

    // a write item answers in the next cycle
    a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> res_push)
        else $error("write item gave no result");

    // the chain never carries a token while a write answer is pending
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_pend_reg && chain_valid[ROUTES]))
        else $error("two results collide");

endmodule

>>> tb/ipv4_route_lookup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_lookup_core_tb
// self-checking bench: loads the route table, then runs directed and random
// lookups and writes under several gateway and route count settings, predicting
// every result in a local copy of the table and comparing each returned item
// ----------------------------------------------------------------------------
module ipv4_route_lookup_core_tb;

    localparam int ROUTES     = rlk_pkg::ROUTES_DEF;
    localparam int IFACES     = rlk_pkg::IFACES_DEF;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 125;

    typedef struct packed {
        logic        req;
        logic [31:0] dest;
        logic [3:0]  slot;
        logic [31:0] mask;
        logic [31:0] value;
        logic [5:0]  prefix;
        logic [3:0]  iface;
    } route_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [4:0]   cfg_data = '0;

    // local copy of the table and registers
    logic [31:0]  tbl_mask [ROUTES];
    logic [31:0]  tbl_value [ROUTES];
    logic [5:0]   tbl_prefix [ROUTES];
    logic [3:0]   tbl_iface [ROUTES];
    logic [4:0]   cur_count = '0;
    logic         cur_gw_present = 1'b0;
    logic [3:0]   cur_gw_iface = '0;

    route_req_t    req_queue [$];
    rlk_pkg::res_t routes_due [$];
    route_req_t    in_flight;
    int unsigned   items_taken = 0;
    int unsigned   tx_gap = 0;
    int unsigned   rx_stall = 0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    bit            steady = 1'b0;
    int unsigned   idle_cycles = 0;
    int unsigned   error_count = 0;

    ipv4_route_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // first-match scan of the table; a write updates the table instead
    function automatic rlk_pkg::res_t lookup_route(input route_req_t r);
        rlk_pkg::res_t res;
        int unsigned   n;
        logic [3:0]    iface;
        logic          ext;
        bit            found;
        iface = '0;
        ext   = 1'b0;
        found = 1'b0;
        res   = '0;
        if (r.req == rlk_pkg::REQ_WRITE)
        begin
            tbl_mask[r.slot]   = r.mask;
            tbl_value[r.slot]  = r.value;
            tbl_prefix[r.slot] = r.prefix;
            tbl_iface[r.slot]  = r.iface;
            res.status = rlk_pkg::ST_WRITTEN;
            return res;
        end
        n = (cur_count > ROUTES) ? ROUTES : cur_count;
        for (int i = 0; i < n; i++)
        begin
            if ((r.dest & tbl_mask[i]) == tbl_value[i])
            begin
                if (tbl_prefix[i] != 0)
                begin
                    iface = tbl_iface[i];
                    found = 1'b1;
                end
                else if (cur_gw_present)
                begin
                    iface = cur_gw_iface;
                    ext   = 1'b1;
                    found = 1'b1;
                end
                break;
            end
        end
        if (found && iface < IFACES)
        begin
            res.status = rlk_pkg::ST_ROUTED;
            res.iface  = iface;
            res.ext    = ext;
        end
        else
            res.status = rlk_pkg::ST_NOROUTE;
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                routes_due.push_back(lookup_route(in_flight));
                items_taken <= items_taken + 1;
            end
            if (s_tvalid && !s_tready)
                ;
            else if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (req_queue.size() != 0)
            begin
                in_flight = req_queue.pop_front();
                s_tdata  <= {2'b00, in_flight.iface, in_flight.prefix, in_flight.value,
                             in_flight.mask, in_flight.slot, in_flight.dest};
                s_tuser  <= in_flight.req;
                s_tvalid <= 1'b1;
                tx_gap   <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off once the run is well under way
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rlk_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (routes_due.size() == 0)
            begin
                $error("unexpected result item: status %0d iface %0d ext %0d",
                       m_tuser, m_tdata[3:0], m_tdata[4]);
                error_count++;
            end
            else
            begin
                want = routes_due.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[3:0] !== want.iface)
                begin
                    $error("out_iface: expected %0d, got %0d", want.iface, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[4] !== want.ext)
                begin
                    $error("via_gw: expected %0d, got %0d", want.ext, m_tdata[4]);
                    error_count++;
                end
            end
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else if (hold_left != 0)
            m_tready <= 1'b0;
        else if (rx_stall != 0)
        begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    // watchdog on cycles with no accepted item anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ipv4_route_lookup_core_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            rlk_pkg::CFG_ROUTE_COUNT: cur_count      = val;
            rlk_pkg::CFG_GW_PRESENT:  cur_gw_present = val[0];
            rlk_pkg::CFG_GW_IFACE:    cur_gw_iface   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic add_write(input logic [3:0] slot, input logic [31:0] mask,
                             input logic [31:0] value, input logic [5:0] prefix,
                             input logic [3:0] iface);
        route_req_t r;
        r        = '0;
        r.req    = rlk_pkg::REQ_WRITE;
        r.dest   = $urandom;
        r.slot   = slot;
        r.mask   = mask;
        r.value  = value;
        r.prefix = prefix;
        r.iface  = iface;
        req_queue.push_back(r);
    endtask

    task automatic add_lookup(input logic [31:0] dest);
        route_req_t r;
        r        = '0;
        r.req    = rlk_pkg::REQ_LOOKUP;
        r.dest   = dest;
        // entry fields are don't-care on a lookup
        r.slot   = 4'($urandom);
        r.mask   = $urandom;
        r.value  = $urandom;
        r.prefix = 6'($urandom);
        r.iface  = 4'($urandom);
        req_queue.push_back(r);
    endtask

    // block has one item in flight, so an empty queue of due results means idle;
    // checked on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (req_queue.size() != 0 || s_tvalid || routes_due.size() != 0)
            @(negedge clk);
        repeat (ROUTES + 4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned r;
        int unsigned len;
        int unsigned k;
        int unsigned span;
        logic [31:0] mask;
        logic [31:0] value;
        logic [5:0]  prefix;
        logic [4:0]  counts [PHASES];

        counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd5, 5'd16, 5'd12, 5'd2};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        cfg_write(rlk_pkg::CFG_ROUTE_COUNT, 5'd16);
        cfg_write(rlk_pkg::CFG_GW_PRESENT, 5'd0);
        cfg_write(rlk_pkg::CFG_GW_IFACE, 5'd0);

        // every slot written before any lookup
        add_write(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 4'd15);
        add_write(4'd1, 32'hFFFF_FFFF, 32'h0000_0000, 6'd32, 4'd1);
        add_write(4'd2, 32'hFFFF_FF00, 32'hC0A8_0100, 6'd24, 4'd2);
        add_write(4'd3, 32'hFF00_0000, 32'h0A00_0000, 6'd8, 4'd3);
        add_write(4'd4, 32'hFFFF_0000, 32'hAC10_0000, 6'd16, 4'd0);
        // default route: stops the scan
        add_write(4'd5, 32'h0000_0000, 32'h0000_0000, 6'd0, 4'd9);
        // value with bits outside the mask never matches
        add_write(4'd6, 32'hFFFF_0000, 32'h0000_FFFF, 6'd31, 4'd6);
        for (int i = 7; i < ROUTES; i++)
            add_write(4'(i), 32'hFFFF_FFFF, $urandom,
                      (i == ROUTES - 1) ? 6'd63 : 6'(i + 1), 4'(i));
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'h0000_0000);
        add_lookup(32'hC0A8_0107);
        add_lookup(32'h0A12_3456);
        add_lookup(32'hAC10_FFFF);
        add_lookup(32'h1234_5678);
        wait_drained();

        cfg_write(rlk_pkg::CFG_GW_PRESENT, 5'd1);
        cfg_write(rlk_pkg::CFG_GW_IFACE, 5'd15);
        add_lookup(32'h1234_5678);
        add_lookup(32'hFFFF_FFFF);
        wait_drained();
        cfg_write(rlk_pkg::CFG_ROUTE_COUNT, 5'd0);
        add_lookup(32'h1234_5678);
        wait_drained();
        cfg_write(rlk_pkg::CFG_ROUTE_COUNT, 5'd31);
        add_lookup(32'h1234_5678);
        wait_drained();
        cfg_write(rlk_pkg::CFG_ROUTE_COUNT, 5'd3);
        add_lookup(32'h1234_5678);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            steady = (p == 3 || p == 7);
            cfg_write(rlk_pkg::CFG_ROUTE_COUNT, counts[p]);
            cfg_write(rlk_pkg::CFG_GW_PRESENT, (p == 0) ? 5'd1 : 5'($urandom_range(0, 1)));
            cfg_write(rlk_pkg::CFG_GW_IFACE, (p == 0) ? 5'd15 : (p == 1) ? 5'd0
                                             : 5'($urandom_range(0, 15)));
            span = (cur_count > ROUTES) ? ROUTES : cur_count;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                r = $urandom_range(99);
                if (r < 12)
                begin
                    len    = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 32);
                    mask   = (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
                    value  = ($urandom_range(99) < 85) ? ($urandom & mask) : $urandom;
                    r      = $urandom_range(99);
                    prefix = (r < 80) ? 6'(len) : (r < 90) ? 6'd0 : 6'($urandom_range(0, 63));
                    add_write(4'($urandom_range(0, 15)), mask, value, prefix,
                              4'($urandom_range(0, 15)));
                end
                else if (r < 77)
                begin
                    // aim at an entry that the scan can reach, when the route count lets it reach any
                    k = (span == 0) ? $urandom_range(0, ROUTES - 1) : $urandom_range(0, span - 1);
                    add_lookup((tbl_value[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]));
                end
                else
                    add_lookup($urandom);
                // keep the queue short so targets track the table
                while (req_queue.size() > 4)
                    @(posedge clk);
            end
            wait_drained();
        end

        if (routes_due.size() != 0)
        begin
            $error("%0d result items never arrived", routes_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ipv4_route_lookup_core_tb: done, clean");
        else
            $display("ipv4_route_lookup_core_tb: done, errors");
        $finish;
    end

endmodule
